@@ rtl/core/scsc_pkg.sv @@
// ----------------------------------------------------------------------------
// scsc_pkg: shared definitions for the stereo compressor and soft clip.
// Register map, reset values and fixed gain formats.
// ----------------------------------------------------------------------------
`default_nettype none

package scsc_pkg;

    localparam int SAMPLE_BITS_DEFAULT = 24;
    localparam int ADDR_BITS           = 5;
    localparam int DATA_BITS           = 32;

    localparam int GAIN_BITS  = 17;
    localparam int QUOT_BITS  = 17;
    localparam int MAKEUP_BITS = 15;
    localparam int THR_BITS    = 8;
    localparam int RATIO_BITS  = 5;
    localparam int COEFF_BITS  = 17;

    localparam logic [GAIN_BITS-1:0]   UNITY_GAIN     = 17'd65536;
    localparam logic [MAKEUP_BITS-1:0] MAKEUP_RESET   = 15'd16384;
    localparam logic [THR_BITS-1:0]    THR_RESET      = 8'd128;
    localparam logic [RATIO_BITS-1:0]  RATIO_RESET    = 5'd0;
    localparam logic [COEFF_BITS-1:0]  ATTACK_RESET   = 17'd1365;
    localparam logic [COEFF_BITS-1:0]  RELEASE_RESET  = 17'd1365;

    typedef enum logic [2:0] {
        REG_MAKEUP    = 3'd0,
        REG_THRESHOLD = 3'd1,
        REG_RATIO     = 3'd2,
        REG_ATTACK    = 3'd3,
        REG_RELEASE   = 3'd4,
        REG_CLIP      = 3'd5
    } reg_index_t;

endpackage

`default_nettype wire

@@ rtl/core/stereo_compressor_soft_clip_unit.sv @@
// ----------------------------------------------------------------------------
// stereo_compressor_soft_clip_unit: stereo peak compressor with soft clip.
// A frame passes the makeup gain and, with a nonzero ratio, the peak detector,
// gain divider (skipped with the peak at or below the threshold) and smoother;
// the soft clip adds a 17-step divider pass and multiplies per channel.
// One shared multiplier and one restoring divider carry all the arithmetic, so
// a new transaction is taken only after the previous result is registered.
// Reset restores the register defaults and sets the smoothed gain to unity.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_compressor_soft_clip_unit #(
    parameter int SAMPLE_BITS = scsc_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [scsc_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [scsc_pkg::DATA_BITS-1:0] pwdata,
    output logic      [scsc_pkg::DATA_BITS-1:0] prdata,
    output logic                                pready,

    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]  left_in,
    input  wire logic signed [SAMPLE_BITS-1:0]  right_in,
    input  wire logic                           block_end,

    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [SAMPLE_BITS-1:0]       left_out,
    output logic signed [SAMPLE_BITS-1:0]       right_out,
    output logic                                block_end_out
);

    import scsc_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int F  = SB - 2;
    localparam int YW = SB + 1;
    localparam int MW = (SB + 1 > 18) ? SB + 1 : 18;
    localparam int PW = 2 * MW;
    localparam int RW = SB + 6;

    localparam logic signed [PW-1:0] HALF14 = PW'(1) << 13;
    localparam logic signed [PW-1:0] HALF16 = PW'(1) << 15;
    localparam logic signed [PW-1:0] FS_P   = PW'(1) << F;
    localparam logic [RW-1:0]        FS27   = RW'(27) << F;
    localparam logic [SB-1:0]        FS3    = SB'(3) << F;
    localparam logic signed [YW-1:0] FS_Y   = YW'(1) << F;
    localparam logic signed [YW-1:0] SMAX   = $signed({2'b00, {(SB-1){1'b1}}});
    localparam logic signed [YW-1:0] SMIN   = $signed({2'b11, {(SB-1){1'b0}}});
    localparam logic [4:0]           LAST_STEP = 5'(QUOT_BITS - 1);

    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL_L,
        S_MUL_R,
        S_GAIN_PREP,
        S_PEAK,
        S_DEN,
        S_DIV_LOAD,
        S_DIV,
        S_SMOOTH1,
        S_SMOOTH2,
        S_APPLY_L,
        S_APPLY_R,
        S_APPLY_DONE,
        S_CLIP_SQ,
        S_CLIP_S,
        S_CLIP_LOAD,
        S_CLIP_MULQ,
        S_CLIP_FIN,
        S_OUT
    } state_t;

    state_t                    state_reg, state_next;

    logic [MAKEUP_BITS-1:0]    mg_reg, mg_next;
    logic [THR_BITS-1:0]       tl_reg, tl_next;
    logic [RATIO_BITS-1:0]     ratio_reg, ratio_next;
    logic [COEFF_BITS-1:0]     att_reg, att_next;
    logic [COEFF_BITS-1:0]     rel_reg, rel_next;
    logic                      clip_reg, clip_next;

    logic signed [SB-1:0]      xl_reg, xl_next;
    logic signed [SB-1:0]      xr_reg, xr_next;
    logic                      be_reg, be_next;
    logic signed [PW-1:0]      prod_reg, prod_next;
    logic signed [YW-1:0]      ml_reg, ml_next;
    logic signed [YW-1:0]      mr_reg, mr_next;
    logic [SB-1:0]             peak_reg, peak_next;
    logic [RW-1:0]             num_reg, num_next;
    logic [RW-1:0]             den_reg, den_next;
    logic [RW-1:0]             rem_reg, rem_next;
    logic [QUOT_BITS-1:0]      q_reg, q_next;
    logic [4:0]                cnt_reg, cnt_next;
    logic                      div_clip_reg, div_clip_next;
    logic [GAIN_BITS-1:0]      g_reg, g_next;
    logic signed [YW-1:0]      yl_reg, yl_next;
    logic signed [YW-1:0]      yr_reg, yr_next;
    logic                      ch_reg, ch_next;
    logic [SB-1:0]             a_reg, a_next;
    logic [RW-1:0]             s_reg, s_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [SB-1:0]      left_out_reg, left_out_next;
    logic signed [SB-1:0]      right_out_reg, right_out_next;
    logic                      be_out_reg, be_out_next;

    logic signed [MW-1:0]      mul_a, mul_b;

    logic                      cfg_write;
    logic [2:0]                cfg_index;
    logic                      lim;
    logic [RW-1:0]             thr_w;
    logic [SB-1:0]             ml_abs, mr_abs, peak_w;
    logic signed [PW-1:0]      rnd14_w, rnd16_w, r_full;
    logic signed [17:0]        diff_w;
    logic [COEFF_BITS-1:0]     coeff_raw, coeff_w;
    logic signed [18:0]        gsum_w;
    logic signed [YW-1:0]      y_sel;
    logic [SB-1:0]             a_w;
    logic [RW-1:0]             trial_w;
    logic                      ge_w;
    logic signed [YW-1:0]      clip_mag, clip_y;
    logic                      out_free;

    function automatic logic [SB-1:0] saturate(input logic signed [YW-1:0] y);
        logic [SB-1:0] r;
        if (y > SMAX)
        begin
            r = SMAX[SB-1:0];
        end
        else if (y < SMIN)
        begin
            r = SMIN[SB-1:0];
        end
        else
        begin
            r = y[SB-1:0];
        end
        return r;
    endfunction

    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];
    assign pready    = 1'b1;

    assign lim     = ratio_reg[RATIO_BITS-1];
    assign thr_w   = RW'(tl_reg) << (F - 7);
    assign ml_abs  = SB'(ml_reg[YW-1] ? -ml_reg : ml_reg);
    assign mr_abs  = SB'(mr_reg[YW-1] ? -mr_reg : mr_reg);
    assign peak_w  = (ml_abs > mr_abs) ? ml_abs : mr_abs;
    assign rnd14_w = (prod_reg + HALF14) >>> 14;
    assign rnd16_w = (prod_reg + HALF16) >>> 16;
    assign r_full  = prod_reg >>> 16;

    assign diff_w    = $signed({1'b0, q_reg}) - $signed({1'b0, g_reg});
    assign coeff_raw = (q_reg < g_reg) ? att_reg : rel_reg;
    assign coeff_w   = (coeff_raw > UNITY_GAIN) ? UNITY_GAIN : coeff_raw;
    assign gsum_w    = $signed({2'b00, g_reg}) + 19'(rnd16_w);

    assign y_sel    = ch_reg ? yr_reg : yl_reg;
    assign a_w      = SB'(y_sel[YW-1] ? -y_sel : y_sel);
    assign clip_mag = (r_full > FS_P) ? FS_Y : YW'(r_full);
    assign clip_y   = y_sel[YW-1] ? -clip_mag : clip_mag;

    assign trial_w = (cnt_reg == 5'd0) ? rem_reg : (rem_reg << 1);
    assign ge_w    = (trial_w >= den_reg);

    assign out_free = !out_valid_reg || !out_stall;

    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        prdata = '0;
        case (cfg_index)
            REG_MAKEUP:    prdata = DATA_BITS'(mg_reg);
            REG_THRESHOLD: prdata = DATA_BITS'(tl_reg);
            REG_RATIO:     prdata = DATA_BITS'(ratio_reg);
            REG_ATTACK:    prdata = DATA_BITS'(att_reg);
            REG_RELEASE:   prdata = DATA_BITS'(rel_reg);
            REG_CLIP:      prdata = DATA_BITS'(clip_reg);
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        mg_next        = mg_reg;
        tl_next        = tl_reg;
        ratio_next     = ratio_reg;
        att_next       = att_reg;
        rel_next       = rel_reg;
        clip_next      = clip_reg;
        xl_next        = xl_reg;
        xr_next        = xr_reg;
        be_next        = be_reg;
        ml_next        = ml_reg;
        mr_next        = mr_reg;
        peak_next      = peak_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        div_clip_next  = div_clip_reg;
        g_next         = g_reg;
        yl_next        = yl_reg;
        yr_next        = yr_reg;
        ch_next        = ch_reg;
        a_next         = a_reg;
        s_next         = s_reg;
        out_valid_next = out_valid_reg;
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;
        be_out_next    = be_out_reg;
        mul_a          = '0;
        mul_b          = '0;

        if (cfg_write)
        begin
            case (cfg_index)
                REG_MAKEUP:    mg_next    = pwdata[MAKEUP_BITS-1:0];
                REG_THRESHOLD: tl_next    = pwdata[THR_BITS-1:0];
                REG_RATIO:     ratio_next = pwdata[RATIO_BITS-1:0];
                REG_ATTACK:    att_next   = pwdata[COEFF_BITS-1:0];
                REG_RELEASE:   rel_next   = pwdata[COEFF_BITS-1:0];
                REG_CLIP:      clip_next  = pwdata[0];
                default:       ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    xl_next    = left_in;
                    xr_next    = right_in;
                    be_next    = block_end;
                    state_next = S_MUL_L;
                end
            end
            S_MUL_L:
            begin
                mul_a      = MW'(xl_reg);
                mul_b      = MW'(mg_reg);
                state_next = S_MUL_R;
            end
            S_MUL_R:
            begin
                ml_next    = YW'(rnd14_w);
                mul_a      = MW'(xr_reg);
                mul_b      = MW'(mg_reg);
                state_next = S_GAIN_PREP;
            end
            S_GAIN_PREP:
            begin
                mr_next = YW'(rnd14_w);
                ch_next = 1'b0;
                if (ratio_reg == '0)
                begin
                    yl_next    = ml_reg;
                    yr_next    = YW'(rnd14_w);
                    state_next = clip_reg ? S_CLIP_SQ : S_OUT;
                end
                else
                begin
                    state_next = S_PEAK;
                end
            end
            S_PEAK:
            begin
                peak_next  = peak_w;
                mul_a      = MW'(thr_w);
                mul_b      = MW'(ratio_reg);
                state_next = S_DEN;
            end
            S_DEN:
            begin
                mul_a         = MW'(peak_reg);
                mul_b         = lim ? MW'(1) : MW'({1'b0, ratio_reg} + 6'd1);
                num_next      = lim ? thr_w : (RW'(peak_reg) + RW'(prod_reg));
                div_clip_next = 1'b0;
                if (RW'(peak_reg) <= thr_w)
                begin
                    q_next     = UNITY_GAIN;
                    state_next = S_SMOOTH1;
                end
                else
                begin
                    state_next = S_DIV_LOAD;
                end
            end
            S_DIV_LOAD:
            begin
                den_next   = RW'(prod_reg);
                rem_next   = num_reg;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = ge_w ? (trial_w - den_reg) : trial_w;
                q_next   = {q_reg[QUOT_BITS-2:0], ge_w};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = div_clip_reg ? S_CLIP_MULQ : S_SMOOTH1;
                end
            end
            S_SMOOTH1:
            begin
                mul_a      = MW'(diff_w);
                mul_b      = MW'(coeff_w);
                state_next = S_SMOOTH2;
            end
            S_SMOOTH2:
            begin
                if (gsum_w < 0)
                begin
                    g_next = '0;
                end
                else if (gsum_w > $signed({2'b00, UNITY_GAIN}))
                begin
                    g_next = UNITY_GAIN;
                end
                else
                begin
                    g_next = gsum_w[GAIN_BITS-1:0];
                end
                state_next = S_APPLY_L;
            end
            S_APPLY_L:
            begin
                mul_a      = MW'(ml_reg);
                mul_b      = MW'(g_reg);
                state_next = S_APPLY_R;
            end
            S_APPLY_R:
            begin
                yl_next    = YW'(rnd16_w);
                mul_a      = MW'(mr_reg);
                mul_b      = MW'(g_reg);
                state_next = S_APPLY_DONE;
            end
            S_APPLY_DONE:
            begin
                yr_next    = YW'(rnd16_w);
                state_next = clip_reg ? S_CLIP_SQ : S_OUT;
            end
            S_CLIP_SQ:
            begin
                if (a_w >= FS3)
                begin
                    if (ch_reg)
                    begin
                        yr_next    = y_sel[YW-1] ? -FS_Y : FS_Y;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        yl_next = y_sel[YW-1] ? -FS_Y : FS_Y;
                        ch_next = 1'b1;
                    end
                end
                else
                begin
                    a_next     = a_w;
                    mul_a      = MW'(a_w);
                    mul_b      = MW'(a_w);
                    state_next = S_CLIP_S;
                end
            end
            S_CLIP_S:
            begin
                s_next     = RW'(prod_reg >>> F);
                state_next = S_CLIP_LOAD;
            end
            S_CLIP_LOAD:
            begin
                rem_next      = FS27 + s_reg;
                den_next      = FS27 + (s_reg << 3) + s_reg;
                cnt_next      = '0;
                div_clip_next = 1'b1;
                state_next    = S_DIV;
            end
            S_CLIP_MULQ:
            begin
                mul_a      = MW'(a_reg);
                mul_b      = MW'(q_reg);
                state_next = S_CLIP_FIN;
            end
            S_CLIP_FIN:
            begin
                if (ch_reg)
                begin
                    yr_next    = clip_y;
                    state_next = S_OUT;
                end
                else
                begin
                    yl_next    = clip_y;
                    ch_next    = 1'b1;
                    state_next = S_CLIP_SQ;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    left_out_next  = saturate(yl_reg);
                    right_out_next = saturate(yr_reg);
                    be_out_next    = be_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mg_reg        <= MAKEUP_RESET;
            tl_reg        <= THR_RESET;
            ratio_reg     <= RATIO_RESET;
            att_reg       <= ATTACK_RESET;
            rel_reg       <= RELEASE_RESET;
            clip_reg      <= 1'b0;
            g_reg         <= UNITY_GAIN;
            cnt_reg       <= '0;
            div_clip_reg  <= 1'b0;
            ch_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mg_reg        <= mg_next;
            tl_reg        <= tl_next;
            ratio_reg     <= ratio_next;
            att_reg       <= att_next;
            rel_reg       <= rel_next;
            clip_reg      <= clip_next;
            g_reg         <= g_next;
            cnt_reg       <= cnt_next;
            div_clip_reg  <= div_clip_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xl_reg        <= xl_next;
        xr_reg        <= xr_next;
        be_reg        <= be_next;
        prod_reg      <= prod_next;
        ml_reg        <= ml_next;
        mr_reg        <= mr_next;
        peak_reg      <= peak_next;
        num_reg       <= num_next;
        den_reg       <= den_next;
        rem_reg       <= rem_next;
        q_reg         <= q_next;
        yl_reg        <= yl_next;
        yr_reg        <= yr_next;
        a_reg         <= a_next;
        s_reg         <= s_next;
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
        be_out_reg    <= be_out_next;
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign left_out      = left_out_reg;
    assign right_out     = right_out_reg;
    assign block_end_out = be_out_reg;

endmodule

`default_nettype wire

@@ tb/tb_stereo_compressor_soft_clip_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_compressor_soft_clip_unit: self-checking testbench for the
// stereo compressor and soft clip.
// Frames are sent over the valid/stall input channel while an internal
// fixed-point model of the makeup gain, peak detector, gain smoother and
// soft clip predicts each output frame. Results are compared field by field
// in order, under random idling, long output holds and register changes
// made through the APB port between traffic phases.
// ----------------------------------------------------------------------------

module tb_stereo_compressor_soft_clip_unit;

    import scsc_pkg::*;

    localparam int     SB         = SAMPLE_BITS_DEFAULT;
    localparam int     FRAC       = SB - 2;
    localparam longint FS         = longint'(1) <<< FRAC;
    localparam longint SMAX       = (longint'(1) <<< (SB - 1)) - 1;
    localparam longint SMIN       = -(longint'(1) <<< (SB - 1));
    localparam longint GAIN_ONE   = longint'(UNITY_GAIN);
    localparam int     HOLD_LEN   = 400;
    localparam int     CYCLE_CAP  = 1500000;
    localparam int     SHOW_MAX   = 10;

    localparam logic [ADDR_BITS-1:0] ADDR_UNMAPPED_LO = 5'd24;
    localparam logic [ADDR_BITS-1:0] ADDR_UNMAPPED_HI = 5'd28;

    typedef struct packed {
        logic signed [SB-1:0] left;
        logic signed [SB-1:0] right;
        logic                 be;
    } frame_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_BITS-1:0]  paddr;
    logic [DATA_BITS-1:0]  pwdata;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic signed [SB-1:0]  left_in;
    logic signed [SB-1:0]  right_in;
    logic                  block_end;
    logic                  out_valid;
    logic                  out_stall;
    logic signed [SB-1:0]  left_out;
    logic signed [SB-1:0]  right_out;
    logic                  block_end_out;

    logic [MAKEUP_BITS-1:0] mk_gain;
    logic [THR_BITS-1:0]    thr_lvl;
    logic [RATIO_BITS-1:0]  ratio_q;
    logic [COEFF_BITS-1:0]  att_coef;
    logic [COEFF_BITS-1:0]  rel_coef;
    logic                   clip_on;
    longint                 kept_gain;

    frame_t expected_frames[$];
    frame_t rx_want;
    int     mismatches;
    int     frames_sent;
    int     frames_seen;
    int     reg_writes;
    int     cycles;
    bit     tx_gaps;
    logic   rx_stalls;
    logic   hold_go;
    logic   hold_seen;
    int     hold_cnt;

    stereo_compressor_soft_clip_unit #(
        .SAMPLE_BITS(SB)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .left_in       (left_in),
        .right_in      (right_in),
        .block_end     (block_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .left_out      (left_out),
        .right_out     (right_out),
        .block_end_out (block_end_out)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip_curve(input longint y);
        longint a;
        longint s;
        longint q;
        longint r;
        a = (y < 0) ? -y : y;
        if (a >= 3 * FS) begin
            r = FS;
        end
        else begin
            s = (a * a) >>> FRAC;
            q = ((27 * FS + s) <<< 16) / (27 * FS + 9 * s);
            r = (a * q) >>> 16;
            if (r > FS)
                r = FS;
        end
        return (y < 0) ? -r : r;
    endfunction

    function automatic logic signed [SB-1:0] smp(input longint v);
        return v[SB-1:0];
    endfunction

    function automatic logic signed [SB-1:0] saturate(input longint y);
        if (y > SMAX)
            y = SMAX;
        if (y < SMIN)
            y = SMIN;
        return smp(y);
    endfunction

    function automatic frame_t compress_frame(input logic signed [SB-1:0] li,
                                              input logic signed [SB-1:0] ri,
                                              input logic be);
        frame_t res;
        longint l;
        longint r;
        longint peak;
        longint thr;
        longint target;
        longint coeff;
        longint n;
        l = rnd_shift(longint'(li) * longint'(mk_gain), 14);
        r = rnd_shift(longint'(ri) * longint'(mk_gain), 14);
        if (ratio_q != 0) begin
            peak = ((l < 0) ? -l : l);
            if (((r < 0) ? -r : r) > peak)
                peak = (r < 0) ? -r : r;
            thr = longint'(thr_lvl) <<< (FRAC - 7);
            if (peak <= thr) begin
                target = GAIN_ONE;
            end
            else if (ratio_q >= 16) begin
                target = (thr <<< 16) / peak;
            end
            else begin
                n = longint'(ratio_q);
                target = ((peak + n * thr) <<< 16) / ((n + 1) * peak);
            end
            coeff = (target < kept_gain) ? longint'(att_coef) : longint'(rel_coef);
            if (coeff > GAIN_ONE)
                coeff = GAIN_ONE;
            kept_gain = kept_gain + rnd_shift(coeff * (target - kept_gain), 16);
            if (kept_gain < 0)
                kept_gain = 0;
            if (kept_gain > GAIN_ONE)
                kept_gain = GAIN_ONE;
            l = rnd_shift(l * kept_gain, 16);
            r = rnd_shift(r * kept_gain, 16);
        end
        if (clip_on) begin
            l = clip_curve(l);
            r = clip_curve(r);
        end
        res.left  = saturate(l);
        res.right = saturate(r);
        res.be    = be;
        return res;
    endfunction

    task automatic log_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= SHOW_MAX)
            $display("Mismatch on %s at frame %0d: expected %0d, got %0d",
                     what, frames_seen, want, got);
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            frames_seen++;
            if (expected_frames.size() == 0) begin
                log_mismatch("unexpected transaction (left_out)", 0, left_out);
            end
            else begin
                rx_want = expected_frames.pop_front();
                if (rx_want.left !== left_out)
                    log_mismatch("left_out", rx_want.left, left_out);
                if (rx_want.right !== right_out)
                    log_mismatch("right_out", rx_want.right, right_out);
                if (rx_want.be !== block_end_out)
                    log_mismatch("block_end_out", rx_want.be, block_end_out);
            end
        end
        if (hold_cnt != 0) begin
            out_stall <= 1'b1;
            hold_cnt  <= hold_cnt - 1;
        end
        else if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_cnt  <= HOLD_LEN;
            out_stall <= 1'b1;
        end
        else if (rx_stalls) begin
            out_stall <= ($urandom_range(99) < 37);
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Timeout after %0d cycles with %0d frames outstanding",
                     cycles, expected_frames.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic cfg_write(input logic [ADDR_BITS-1:0] addr,
                             input logic [DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        reg_writes++;
        case (addr[ADDR_BITS-1:2])
            REG_MAKEUP:    mk_gain  = data[MAKEUP_BITS-1:0];
            REG_THRESHOLD: thr_lvl  = data[THR_BITS-1:0];
            REG_RATIO:     ratio_q  = data[RATIO_BITS-1:0];
            REG_ATTACK:    att_coef = data[COEFF_BITS-1:0];
            REG_RELEASE:   rel_coef = data[COEFF_BITS-1:0];
            REG_CLIP:      clip_on  = data[0];
            default:       ;
        endcase
    endtask

    task automatic cfg_set(input reg_index_t r, input logic [DATA_BITS-1:0] data);
        cfg_write({r, 2'b00}, data);
    endtask

    task automatic send_frame(input logic signed [SB-1:0] l,
                              input logic signed [SB-1:0] r,
                              input logic be);
        while (tx_gaps && ($urandom_range(99) < 37)) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        left_in   <= l;
        right_in  <= r;
        block_end <= be;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_frames.push_back(compress_frame(l, r, be));
        frames_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_frame(smp(SMAX), smp(SMIN), 1'b0);
        send_frame(smp(SMIN), smp(SMAX), 1'b1);
        send_frame(smp(0), smp(0), 1'b0);
        send_frame(smp(1), smp(-1), 1'b1);
    endtask

    task automatic test_makeup_extremes();
        wait_idle();
        cfg_set(REG_MAKEUP, 32'd32767);
        send_frame(smp(SMAX), smp(SMIN), 1'b0);
        send_frame(smp(FS), smp(-FS), 1'b1);
        wait_idle();
        cfg_set(REG_MAKEUP, 32'd0);
        send_frame(smp(SMAX), smp(SMIN), 1'b0);
    endtask

    task automatic test_soft_clip();
        wait_idle();
        cfg_set(REG_MAKEUP, 32'd16384);
        cfg_set(REG_CLIP, 32'd1);
        send_frame(smp(0), smp(FS), 1'b0);
        send_frame(smp(SMAX), smp(-FS / 2), 1'b0);
        wait_idle();
        cfg_set(REG_MAKEUP, 32'd24576);
        send_frame(smp(SMAX), smp(SMIN), 1'b1);
        send_frame(smp(2 * FS), smp(-2 * FS), 1'b0);
        wait_idle();
        cfg_set(REG_CLIP, 32'd0);
        cfg_set(REG_MAKEUP, 32'd16384);
    endtask

    task automatic test_compression();
        wait_idle();
        cfg_set(REG_RATIO, 32'd3);
        cfg_set(REG_THRESHOLD, 32'd64);
        cfg_set(REG_ATTACK, 32'd65536);
        cfg_set(REG_RELEASE, 32'd4096);
        send_frame(smp(FS + FS / 2), smp(-1000), 1'b0);
        send_frame(smp(1000), smp(-1000), 1'b0);
        send_frame(smp(FS / 2), smp(-FS / 2), 1'b1);
        wait_idle();
        cfg_set(REG_RATIO, 32'd15);
        send_frame(smp(-FS), smp(SMAX), 1'b0);
    endtask

    task automatic test_limiter();
        wait_idle();
        cfg_set(REG_RATIO, 32'd16);
        cfg_set(REG_THRESHOLD, 32'd32);
        send_frame(smp(FS), smp(SMIN), 1'b0);
        wait_idle();
        cfg_set(REG_RATIO, 32'd31);
        cfg_set(REG_THRESHOLD, 32'd0);
        send_frame(smp(5), smp(0), 1'b0);
        send_frame(smp(0), smp(0), 1'b1);
        wait_idle();
        cfg_set(REG_RATIO, 32'd4);
        cfg_set(REG_ATTACK, 32'd0);
        cfg_set(REG_RELEASE, 32'd131071);
        send_frame(smp(-7), smp(3), 1'b0);
        send_frame(smp(FS), smp(FS), 1'b0);
    endtask

    task automatic test_wide_registers();
        wait_idle();
        cfg_set(REG_MAKEUP, 32'hFFFF_C000);
        cfg_set(REG_THRESHOLD, 32'hABCD_EFC8);
        cfg_set(REG_RATIO, 32'hFFFF_FFE2);
        cfg_set(REG_ATTACK, 32'hFFFE_0800);
        cfg_set(REG_RELEASE, 32'h1234_0100);
        cfg_set(REG_CLIP, 32'hFFFF_FFFE);
        cfg_write(ADDR_UNMAPPED_LO, 32'hFFFF_FFFF);
        cfg_write(ADDR_UNMAPPED_HI, 32'h0000_0000);
        send_frame(smp(SMAX), smp(FS / 3), 1'b1);
        send_frame(smp(-FS / 4), smp(FS / 8), 1'b0);
    endtask

    task automatic test_backpressure();
        wait_idle();
        cfg_set(REG_RATIO, 32'd2);
        cfg_set(REG_THRESHOLD, 32'd40);
        cfg_set(REG_ATTACK, 32'd8000);
        cfg_set(REG_RELEASE, 32'd500);
        tx_gaps = 1'b0;
        rx_stalls <= 1'b0;
        hold_go <= ~hold_go;
        repeat (12)
            send_frame(smp($urandom), smp($urandom), 1'($urandom_range(1)));
        wait_idle();
        tx_gaps = 1'b1;
        rx_stalls <= 1'b1;
        repeat (12)
            send_frame(smp($urandom), smp($urandom), 1'($urandom_range(1)));
    endtask

    function automatic logic [DATA_BITS-1:0] pick_coeff();
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return 32'd65536;
            2:       return 32'd131071;
            3, 4:    return 32'($urandom_range(65536));
            default: return 32'($urandom);
        endcase
    endfunction

    task automatic cfg_randomize(input int phase);
        logic [DATA_BITS-1:0] mk;
        logic [DATA_BITS-1:0] th;
        logic [DATA_BITS-1:0] ra;
        case ($urandom_range(4))
            0:       mk = 32'd16384;
            1:       mk = 32'($urandom_range(16384, 32767));
            2:       mk = 32'($urandom);
            default: mk = 32'($urandom_range(4096, 24576));
        endcase
        th = ($urandom_range(3) == 0) ? 32'($urandom) : 32'($urandom_range(128));
        case ($urandom_range(3))
            0:       ra = 32'd0;
            1:       ra = 32'($urandom_range(16, 31));
            default: ra = 32'($urandom_range(1, 15));
        endcase
        if (phase == 0) begin
            mk = 32'd32767;
            th = 32'd255;
            ra = 32'd31;
        end
        else if (phase == 1) begin
            mk = 32'd0;
            th = 32'd0;
            ra = 32'd0;
        end
        cfg_set(REG_MAKEUP, mk);
        cfg_set(REG_THRESHOLD, th);
        cfg_set(REG_RATIO, ra);
        cfg_set(REG_ATTACK, (phase == 0) ? 32'd131071 : (phase == 1) ? 32'd0 : pick_coeff());
        cfg_set(REG_RELEASE, (phase == 0) ? 32'd131071 : (phase == 1) ? 32'd0 : pick_coeff());
        cfg_set(REG_CLIP, (phase == 0) ? 32'd1 : (phase == 1) ? 32'd0 : 32'($urandom));
    endtask

    function automatic logic signed [SB-1:0] pick_sample(input int level);
        longint v;
        case (level)
            0: v = longint'($urandom);
            1: begin
                case ($urandom_range(3))
                    0:       v = SMAX;
                    1:       v = SMIN;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
            2: v = longint'($urandom_range((1 << $urandom_range(12)) * 2)) -
                   (longint'(1) <<< $urandom_range(12));
            3: begin
                v = (longint'(thr_lvl) <<< (FRAC - 7)) + longint'($urandom_range(4096)) - 2048;
                if ($urandom_range(1))
                    v = -v;
            end
            default: begin
                v = longint'($urandom_range(3)) * FS + longint'($urandom_range(65536)) - 32768;
                if ($urandom_range(1))
                    v = -v;
            end
        endcase
        return smp(v);
    endfunction

    task automatic test_random_phases();
        int level;
        int burst;
        int sent;
        for (int phase = 0; phase < 10; phase++) begin
            wait_idle();
            cfg_randomize(phase);
            tx_gaps = (phase != 3);
            rx_stalls <= (phase != 3);
            if (phase == 6)
                hold_go <= ~hold_go;
            sent = 0;
            while (sent < 200) begin
                level = $urandom_range(4);
                burst = $urandom_range(1, 40);
                repeat (burst) begin
                    send_frame(pick_sample(level),
                               ($urandom_range(3) == 0) ? pick_sample($urandom_range(4))
                                                        : pick_sample(level),
                               1'($urandom_range(7) == 0));
                    sent++;
                end
            end
        end
        tx_gaps = 1'b1;
        rx_stalls <= 1'b1;
    endtask

    initial begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        left_in     = '0;
        right_in    = '0;
        block_end   = 1'b0;
        out_stall   = 1'b0;
        rx_stalls   = 1'b1;
        hold_go     = 1'b0;
        hold_seen   = 1'b0;
        hold_cnt    = 0;
        tx_gaps     = 1'b1;
        mismatches  = 0;
        frames_sent = 0;
        frames_seen = 0;
        reg_writes  = 0;
        cycles      = 0;
        mk_gain     = MAKEUP_RESET;
        thr_lvl     = THR_RESET;
        ratio_q     = RATIO_RESET;
        att_coef    = ATTACK_RESET;
        rel_coef    = RELEASE_RESET;
        clip_on     = 1'b0;
        kept_gain   = GAIN_ONE;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_makeup_extremes();
        test_soft_clip();
        test_compression();
        test_limiter();
        test_wide_registers();
        test_backpressure();
        test_random_phases();

        wait_idle();
        repeat (100) @(posedge clk);
        if (expected_frames.size() != 0)
            mismatches += expected_frames.size();

        $display("Sent %0d frames and checked %0d results across %0d register writes,",
                 frames_sent, frames_seen, reg_writes);
        $display("covering bypass, compression, limiting, soft clip and output holds.");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
